@@ rtl/sha1_message_digest_unit_macros.svh @@
// Assertion macros for the checker file of the SHA-1 digest unit.
// Needs nothing else; the user supplies the clock and reset names to SHA1MD_ASSERT_CLK.
`ifndef SHA1_MESSAGE_DIGEST_UNIT_MACROS_SVH
`define SHA1_MESSAGE_DIGEST_UNIT_MACROS_SVH

// Concurrent assertion on a named clock, masked while reset is asserted.
`define SHA1MD_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, on the standard clock and reset ports of this block (i_clk, i_rst_n).
`define SHA1MD_ASSERT(lbl, prop, msg) \
    `SHA1MD_ASSERT_CLK(lbl, i_clk, i_rst_n, prop, msg)

`endif

@@ rtl/sha1md_pkg.sv @@
// Types, constants and round functions of the SHA-1 digest unit.
// Used by the datapath, the sequencer, the top level and the checker.
package sha1md_pkg;

    localparam int NUM_ROUNDS   = 80;
    localparam int NUM_WORDS    = 5;
    localparam int LEN_POS      = 56;

    localparam logic [2:0] LAST_WORD_IDX = 3'(NUM_WORDS - 1);
    localparam logic [7:0] PAD_MARK      = 8'h80;

    localparam logic [31:0] ROUND_K0 = 32'h5A827999;
    localparam logic [31:0] ROUND_K1 = 32'h6ED9EBA1;
    localparam logic [31:0] ROUND_K2 = 32'h8F1BBCDC;
    localparam logic [31:0] ROUND_K3 = 32'hCA62C1D6;

    localparam logic [4:0][31:0] CHAIN_INIT = {
        32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
    };

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } t_in;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out;

    // Commands from the sequencer to the datapath for one cycle.
    typedef struct packed {
        logic       push_byte;
        logic [7:0] byte_val;
        logic       load_work;
        logic       do_round;
        logic [6:0] round;
        logic       add_chain;
        logic       init_chain;
        logic [2:0] word_sel;
    } t_dp_cmd;

    function automatic logic [31:0] sha1md_f(
        input logic [6:0]  rnd,
        input logic [31:0] b,
        input logic [31:0] c,
        input logic [31:0] d
    );
        logic [31:0] f;
        if (rnd < 7'd20) begin
            f = (b & c) | (~b & d);
        end else if (rnd < 7'd40) begin
            f = b ^ c ^ d;
        end else if (rnd < 7'd60) begin
            f = (b & c) | (b & d) | (c & d);
        end else begin
            f = b ^ c ^ d;
        end
        return f;
    endfunction

    function automatic logic [31:0] sha1md_k(input logic [6:0] rnd);
        logic [31:0] k;
        if (rnd < 7'd20) begin
            k = ROUND_K0;
        end else if (rnd < 7'd40) begin
            k = ROUND_K1;
        end else if (rnd < 7'd60) begin
            k = ROUND_K2;
        end else begin
            k = ROUND_K3;
        end
        return k;
    endfunction

endpackage

@@ rtl/sha1md_datapath.sv @@
// Round datapath of the SHA-1 digest unit: message window, working words,
// chaining words and the single shared round adder. Depends on sha1md_pkg.
module sha1md_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sha1md_pkg::t_dp_cmd  i_cmd,
    output logic [31:0]          o_chain_word
);
    import sha1md_pkg::*;

    // Window word 0 is the oldest; bytes and new schedule words enter at word 15.
    logic [0:15][31:0] r_sched, n_sched;
    logic [511:0]      sched_flat;
    logic [4:0][31:0]  r_work, n_work;
    logic [4:0][31:0]  r_chain, n_chain;
    logic [31:0]       round_sum;
    logic [31:0]       sched_mix;

    assign sched_flat   = r_sched;
    assign o_chain_word = r_chain[i_cmd.word_sel];

    always_comb begin
        sched_mix = r_sched[13] ^ r_sched[8] ^ r_sched[2] ^ r_sched[0];
        round_sum = {r_work[0][26:0], r_work[0][31:27]}
                  + sha1md_f(i_cmd.round, r_work[1], r_work[2], r_work[3])
                  + r_work[4] + sha1md_k(i_cmd.round) + r_sched[0];

        n_sched = r_sched;
        n_work  = r_work;
        n_chain = r_chain;

        if (i_cmd.push_byte) begin
            n_sched = {sched_flat[503:0], i_cmd.byte_val};
        end
        if (i_cmd.load_work) begin
            n_work = r_chain;
        end
        if (i_cmd.do_round) begin
            n_work[4] = r_work[3];
            n_work[3] = r_work[2];
            n_work[2] = {r_work[1][1:0], r_work[1][31:2]};
            n_work[1] = r_work[0];
            n_work[0] = round_sum;
            n_sched   = {sched_flat[479:0], sched_mix[30:0], sched_mix[31]};
        end
        if (i_cmd.add_chain) begin
            for (int i = 0; i < NUM_WORDS; i++) begin
                n_chain[i] = r_chain[i] + r_work[i];
            end
        end
        if (i_cmd.init_chain) begin
            n_chain = CHAIN_INIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain <= CHAIN_INIT;
        end else begin
            r_chain <= n_chain;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sched <= n_sched;
        r_work  <= n_work;
    end

endmodule

@@ rtl/sha1md_ctrl.sv @@
// Sequencer of the SHA-1 digest unit: byte intake, padding, round count,
// bit length and result delivery. Depends on sha1md_pkg.
module sha1md_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  sha1md_pkg::t_in      i_in_data,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output sha1md_pkg::t_out     o_out_data,
    output sha1md_pkg::t_dp_cmd  o_cmd,
    input  logic [31:0]          i_chain_word
);
    import sha1md_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_PAD    = 6'b000010,
        ST_LOAD   = 6'b000100,
        ST_ROUND  = 6'b001000,
        ST_UPDATE = 6'b010000,
        ST_EMIT   = 6'b100000
    } t_state;

    t_state      r_state, n_state;
    logic [5:0]  r_fill, n_fill;
    logic [63:0] r_bits, n_bits;
    logic [6:0]  r_round, n_round;
    logic        r_final, n_final;
    logic        r_pad_first, n_pad_first;
    logic        r_extra, n_extra;
    logic        r_out_valid, n_out_valid;
    logic [2:0]  r_widx, n_widx;
    t_out        r_out, n_out;
    logic [63:0] len_shift;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    // The length byte at fill position 56 + j is byte j of the big-endian count.
    assign len_shift   = r_bits << {r_fill[2:0], 3'b000};

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_bits      = r_bits;
        n_round     = r_round;
        n_final     = r_final;
        n_pad_first = r_pad_first;
        n_extra     = r_extra;
        n_out_valid = r_out_valid;
        n_widx      = r_widx;
        n_out       = r_out;
        o_cmd          = '0;
        o_cmd.round    = r_round;
        o_cmd.word_sel = r_widx;

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_final     = i_in_data.end_of_message;
                    n_pad_first = i_in_data.end_of_message;
                    if (i_in_data.byte_present) begin
                        o_cmd.push_byte = 1'b1;
                        o_cmd.byte_val  = i_in_data.data_byte;
                        n_bits          = r_bits + 64'd8;
                        n_fill          = r_fill + 6'd1;
                    end
                    if (i_in_data.byte_present && (r_fill == 6'd63)) begin
                        n_state = ST_LOAD;
                    end else if (i_in_data.end_of_message) begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                o_cmd.push_byte = 1'b1;
                n_fill          = r_fill + 6'd1;
                if (r_pad_first) begin
                    o_cmd.byte_val = PAD_MARK;
                    n_pad_first    = 1'b0;
                    // No room left for the length: it goes in one more block.
                    n_extra        = (r_fill >= 6'(LEN_POS));
                end else if ((r_fill >= 6'(LEN_POS)) && !r_extra) begin
                    o_cmd.byte_val = len_shift[63:56];
                end else begin
                    o_cmd.byte_val = 8'h00;
                end
                if (r_fill == 6'd63) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                o_cmd.load_work = 1'b1;
                n_round         = '0;
                n_state         = ST_ROUND;
            end
            ST_ROUND: begin
                o_cmd.do_round = 1'b1;
                n_round        = r_round + 7'd1;
                if (r_round == 7'(NUM_ROUNDS - 1)) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                o_cmd.add_chain = 1'b1;
                if (!r_final) begin
                    n_state = ST_IDLE;
                end else if (r_pad_first || r_extra) begin
                    n_extra = 1'b0;
                    n_state = ST_PAD;
                end else begin
                    n_widx      = '0;
                    n_out_valid = 1'b0;
                    n_state     = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!r_out_valid) begin
                    n_out.digest_word = i_chain_word;
                    n_out.word_index  = r_widx;
                    n_out.last_word   = (r_widx == LAST_WORD_IDX);
                    n_out_valid       = 1'b1;
                end else if (i_out_ready) begin
                    n_out_valid = 1'b0;
                    if (r_widx == LAST_WORD_IDX) begin
                        o_cmd.init_chain = 1'b1;
                        n_bits           = '0;
                        n_fill           = '0;
                        n_final          = 1'b0;
                        n_state          = ST_IDLE;
                    end else begin
                        n_widx = r_widx + 3'd1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_bits      <= '0;
            r_round     <= '0;
            r_final     <= 1'b0;
            r_pad_first <= 1'b0;
            r_extra     <= 1'b0;
            r_out_valid <= 1'b0;
            r_widx      <= '0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_bits      <= n_bits;
            r_round     <= n_round;
            r_final     <= n_final;
            r_pad_first <= n_pad_first;
            r_extra     <= n_extra;
            r_out_valid <= n_out_valid;
            r_widx      <= n_widx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

endmodule

@@ rtl/sha1_message_digest_unit.sv @@
// Top level of the SHA-1 digest unit: sequencer plus round datapath.
// Depends on sha1md_pkg, sha1md_ctrl and sha1md_datapath.

// Takes one message byte per input transfer, with an end mark on the last
// transfer of a message (a transfer with no byte may carry the end mark, which
// also yields the digest of the empty message). A byte that does not complete
// a 64-byte block and carries no end mark leaves the input ready. The byte
// that completes a block starts a compression: the working words are loaded,
// 80 rounds run through the single round adder, and the result is folded into
// the chaining words; the ready output is low meanwhile. The end mark pads one
// byte per cycle up to the end of the block (one or two blocks, each followed
// by a compression), then the five digest words h0..h4 come out as five
// transfers, each presented only after the previous one is taken; the fifth
// carries last_word. After that transfer the unit is ready for the next message.
module sha1_message_digest_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  sha1md_pkg::t_in   i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output sha1md_pkg::t_out  o_out_data
);
    import sha1md_pkg::*;

    t_dp_cmd     dp_cmd;
    logic [31:0] chain_word;

    sha1md_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_data    (i_in_data),
        .o_in_ready   (o_in_ready),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_data   (o_out_data),
        .o_cmd        (dp_cmd),
        .i_chain_word (chain_word)
    );

    sha1md_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .o_chain_word (chain_word)
    );

endmodule

@@ rtl/sha1md_checker.sv @@
// Port-level checks for the SHA-1 digest unit, bound to the top level.
// Depends on sha1md_pkg and sha1_message_digest_unit_macros.svh.
`include "sha1_message_digest_unit_macros.svh"

module sha1md_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              o_in_ready,
    input  sha1md_pkg::t_in   i_in_data,
    input  logic              o_out_valid,
    input  logic              i_out_ready,
    input  sha1md_pkg::t_out  o_out_data
);
    import sha1md_pkg::*;

    // A stalled result transfer keeps its digest word.
    `SHA1MD_ASSERT(a_out_hold,
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data),
        "result changed while stalled")

    // No new byte is taken while digest words are still being delivered.
    `SHA1MD_ASSERT(a_busy_out,
        o_out_valid |-> !o_in_ready,
        "input ready while a digest is pending")

    // The last flag marks exactly the fifth chaining word.
    `SHA1MD_ASSERT(a_last_idx,
        o_out_valid |-> (o_out_data.last_word == (o_out_data.word_index == LAST_WORD_IDX)),
        "last_word does not match word_index")

    // An end mark starts padding or a block compression, so the unit is busy on the next cycle.
    `SHA1MD_ASSERT(a_eom_busy,
        i_in_valid && o_in_ready && i_in_data.end_of_message |=> !o_in_ready,
        "input ready right after an end mark")

    // Once the final digest word is taken, the next message may start.
    `SHA1MD_ASSERT(a_ready_after,
        o_out_valid && i_out_ready && o_out_data.last_word |=> o_in_ready && !o_out_valid,
        "not ready after the digest")

endmodule

bind sha1_message_digest_unit sha1md_checker u_sha1md_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

@@ tb/sha1_message_digest_unit_test.sv @@
// Self-checking testbench for the SHA-1 message digest unit.
// Depends on sha1md_pkg for the transfer types and on the sha1_message_digest_unit RTL.
module sha1_message_digest_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import sha1md_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 300;

    typedef enum logic [1:0] {
        KNOWN_NONE,
        KNOWN_EMPTY,
        KNOWN_ABC
    } t_known_digest;

    typedef struct {
        t_in           item;
        t_known_digest known;
    } t_stim_row;

    // Published digests, h0 in the lowest slot.
    localparam logic [4:0][31:0] EMPTY_DIGEST = {
        32'hafd80709, 32'h95601890, 32'h3255bfef, 32'h5e6b4b0d, 32'hda39a3ee
    };
    localparam logic [4:0][31:0] ABC_DIGEST = {
        32'h9cd0d89d, 32'h7850c26c, 32'hba3e2571, 32'h4706816a, 32'ha9993e36
    };
    localparam logic [4:0][31:0] H_INIT = {
        32'hc3d2e1f0, 32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
    };

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    t_in  in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    t_out out_data;

    sha1_message_digest_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    // Digest predictor state.
    logic [4:0][31:0] chain_h;
    logic [7:0]       blk_bytes [64];
    int               blk_fill;
    logic [63:0]      msg_bits;

    t_out digest_words_due [$];
    int   error_count = 0;
    int   msg_items = 0;
    int   filler_items = 0;
    int   digests_done = 0;
    int   words_checked = 0;
    int   cycle_count = 0;
    int   out_stall_left = 0;
    bit   calm_tail = 1'b0;

    t_stim_row directed_rows [17] = '{
        '{'{8'h00, 1'b0, 1'b1}, KNOWN_EMPTY},
        '{'{8'hff, 1'b0, 1'b0}, KNOWN_NONE},
        '{'{8'h00, 1'b0, 1'b0}, KNOWN_NONE},
        '{'{8'hff, 1'b0, 1'b1}, KNOWN_EMPTY},
        '{'{8'h61, 1'b1, 1'b0}, KNOWN_NONE},
        '{'{8'haa, 1'b0, 1'b0}, KNOWN_NONE},
        '{'{8'h62, 1'b1, 1'b0}, KNOWN_NONE},
        '{'{8'h63, 1'b1, 1'b1}, KNOWN_ABC},
        '{'{8'h61, 1'b1, 1'b0}, KNOWN_NONE},
        '{'{8'h62, 1'b1, 1'b0}, KNOWN_NONE},
        '{'{8'h63, 1'b1, 1'b0}, KNOWN_NONE},
        '{'{8'h55, 1'b0, 1'b1}, KNOWN_ABC},
        '{'{8'h00, 1'b1, 1'b1}, KNOWN_NONE},
        '{'{8'hff, 1'b1, 1'b1}, KNOWN_NONE},
        '{'{8'hff, 1'b1, 1'b0}, KNOWN_NONE},
        '{'{8'h00, 1'b1, 1'b0}, KNOWN_NONE},
        '{'{8'h80, 1'b1, 1'b1}, KNOWN_NONE}
    };

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [31:0] rot_left(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    task automatic restart_chain();
        chain_h = H_INIT;
        blk_fill = 0;
        msg_bits = '0;
    endtask

    task automatic compress_block();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, e, f, k, t;
        int r;
        for (r = 0; r < 16; r++) begin
            w[r] = {blk_bytes[4*r], blk_bytes[4*r+1], blk_bytes[4*r+2], blk_bytes[4*r+3]};
        end
        a = chain_h[0];
        b = chain_h[1];
        c = chain_h[2];
        d = chain_h[3];
        e = chain_h[4];
        for (r = 0; r < 80; r++) begin
            if (r >= 16) begin
                w[r % 16] = rot_left(w[(r + 13) % 16] ^ w[(r + 8) % 16]
                                     ^ w[(r + 2) % 16] ^ w[r % 16], 1);
            end
            if (r < 20) begin
                f = (b & c) | (~b & d);
                k = 32'h5a827999;
            end else if (r < 40) begin
                f = b ^ c ^ d;
                k = 32'h6ed9eba1;
            end else if (r < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = 32'h8f1bbcdc;
            end else begin
                f = b ^ c ^ d;
                k = 32'hca62c1d6;
            end
            t = rot_left(a, 5) + f + e + k + w[r % 16];
            e = d;
            d = c;
            c = rot_left(b, 30);
            b = a;
            a = t;
        end
        chain_h[0] += a;
        chain_h[1] += b;
        chain_h[2] += c;
        chain_h[3] += d;
        chain_h[4] += e;
    endtask

    // Applies one accepted transfer to the predictor and queues the digest
    // words it finishes. A published digest, where given, replaces the
    // predicted words.
    task automatic absorb_item(input t_in it, input t_known_digest known);
        t_out w;
        int i;
        if (it.byte_present) begin
            blk_bytes[blk_fill] = it.data_byte;
            blk_fill++;
            msg_bits += 64'd8;
            if (blk_fill == 64) begin
                compress_block();
                blk_fill = 0;
            end
        end
        if (it.end_of_message) begin
            blk_bytes[blk_fill] = 8'h80;
            blk_fill++;
            // No room left for the length field: close this block first.
            if (blk_fill > 56) begin
                for (i = blk_fill; i < 64; i++) blk_bytes[i] = 8'h00;
                compress_block();
                blk_fill = 0;
            end
            for (i = blk_fill; i < 56; i++) blk_bytes[i] = 8'h00;
            for (i = 0; i < 8; i++) blk_bytes[56 + i] = msg_bits[63 - 8*i -: 8];
            compress_block();
            for (i = 0; i < 5; i++) begin
                case (known)
                    KNOWN_EMPTY: w.digest_word = EMPTY_DIGEST[i];
                    KNOWN_ABC:   w.digest_word = ABC_DIGEST[i];
                    default:     w.digest_word = chain_h[i];
                endcase
                w.word_index = 3'(i);
                w.last_word = (i == 4);
                digest_words_due = {digest_words_due, w};
            end
            digests_done++;
            restart_chain();
        end
    endtask

    task automatic send_item(input t_in it, input t_known_digest known);
        int gap;
        if (!calm_tail && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 13);
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        if (it.byte_present || it.end_of_message) begin
            msg_items++;
        end else begin
            filler_items++;
        end
        absorb_item(it, known);
    endtask

    task automatic check_word(input t_out got);
        t_out want;
        if (digest_words_due.size() == 0) begin
            $display("%0t: digest word with nothing expected: %h idx %0d last %0b",
                     $realtime, got.digest_word, got.word_index, got.last_word);
            error_count++;
        end else begin
            want = digest_words_due.pop_front();
            words_checked++;
            if (got.digest_word !== want.digest_word) begin
                $display("%0t: digest_word mismatch, expected %h, actual %h",
                         $realtime, want.digest_word, got.digest_word);
                error_count++;
            end
            if (got.word_index !== want.word_index) begin
                $display("%0t: word_index mismatch, expected %0d, actual %0d",
                         $realtime, want.word_index, got.word_index);
                error_count++;
            end
            if (got.last_word !== want.last_word) begin
                $display("%0t: last_word mismatch, expected %0b, actual %0b",
                         $realtime, want.last_word, got.last_word);
                error_count++;
            end
        end
    endtask

    // Result side: check each transfer, then pick the next ready value.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_valid && out_ready) check_word(out_data);
            if (out_stall_left > 0) begin
                out_stall_left--;
                out_ready <= 1'b0;
            end else if (!calm_tail && $urandom_range(0, 5) == 0) begin
                out_stall_left = $urandom_range(1, 13) - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $realtime, cycle_count);
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        int span_lens [3] = '{55, 56, 64};
        int row;
        int len;
        int n;
        int msg_no;
        int base_items;
        int base_digests;
        bit end_on_byte;
        t_in it;

        restart_chain();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (row = 0; row < 17; row++) begin
            send_item(directed_rows[row].item, directed_rows[row].known);
        end

        // Hold off until the directed digests have all drained.
        in_valid <= 1'b0;
        while (digest_words_due.size() != 0) @(posedge i_clk);

        base_items = msg_items;
        base_digests = digests_done;
        msg_no = 0;
        while (msg_items - base_items < 200 || digests_done - base_digests < 12) begin
            // The first messages straddle the padding boundary and a full block.
            if (msg_no < 3) begin
                len = span_lens[msg_no];
            end else if ($urandom_range(0, 5) == 0) begin
                len = $urandom_range(57, 70);
            end else begin
                len = $urandom_range(0, 15);
            end
            end_on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
            for (n = 0; n < len; n++) begin
                if ($urandom_range(0, 7) == 0) begin
                    it.data_byte = 8'($urandom_range(0, 255));
                    it.byte_present = 1'b0;
                    it.end_of_message = 1'b0;
                    send_item(it, KNOWN_NONE);
                end
                it.data_byte = 8'($urandom_range(0, 255));
                it.byte_present = 1'b1;
                it.end_of_message = end_on_byte && (n == len - 1);
                send_item(it, KNOWN_NONE);
            end
            if (!end_on_byte) begin
                it.data_byte = 8'($urandom_range(0, 255));
                it.byte_present = 1'b0;
                it.end_of_message = 1'b1;
                send_item(it, KNOWN_NONE);
            end
            msg_no++;
            if (msg_items - base_items >= 160) calm_tail = 1'b1;
        end
        in_valid <= 1'b0;

        while (digest_words_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d message transfers and %0d filler transfers over %0d messages,",
                 msg_items, filler_items, digests_done);
        $display("including empty, one-block and two-block padding; %0d digest words checked.",
                 words_checked);
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

@@ sha1_message_digest_unit.f @@
+incdir+rtl
rtl/sha1md_pkg.sv
rtl/sha1md_datapath.sv
rtl/sha1md_ctrl.sv
rtl/sha1_message_digest_unit.sv
rtl/sha1md_checker.sv
tb/sha1_message_digest_unit_test.sv
